// ===== src/mpq_pkg.sv =====
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VALUE_W = 32;
    localparam int PRI_W = 8;
    localparam int COUNT_OUT_W = 5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                      valid;
        logic [PRI_W-1:0]          pri;
        logic signed [VALUE_W-1:0] value;
    } cell_t;

    typedef struct packed {
        logic                      enq;
        logic                      deq;
        logic [PRI_W-1:0]          pri;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== src/mpq_cell.sv =====
`timescale 1ns / 1ps

module mpq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mpq_pkg::cell_ctrl_t ctrl,
    input  mpq_pkg::cell_t     left_cell,
    input  logic               left_go,
    input  mpq_pkg::cell_t     right_cell,
    output mpq_pkg::cell_t     slot,
    output logic               go
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [mpq_pkg::PRI_W-1:0]         pri_reg;
    logic [mpq_pkg::PRI_W-1:0]         pri_next;
    logic signed [mpq_pkg::VALUE_W-1:0] value_reg;
    logic signed [mpq_pkg::VALUE_W-1:0] value_next;

    // A new entry belongs at or before this cell when the cell is free or holds a
    // strictly larger priority number, so equal priorities keep insertion order.
    assign go = !valid_reg || (ctrl.pri < pri_reg);

    assign slot.valid = valid_reg;
    assign slot.pri   = pri_reg;
    assign slot.value = value_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pri_next   = pri_reg;
        value_next = value_reg;
        if (ctrl.enq && go)
        begin
            if (left_go)
            begin
                valid_next = left_cell.valid;
                pri_next   = left_cell.pri;
                value_next = left_cell.value;
            end
            else
            begin
                valid_next = 1'b1;
                pri_next   = ctrl.pri;
                value_next = ctrl.value;
            end
        end
        else if (ctrl.deq)
        begin
            valid_next = right_cell.valid;
            pri_next   = right_cell.pri;
            value_next = right_cell.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg   <= pri_next;
        value_reg <= value_next;
    end

endmodule

// ===== src/min_priority_queue.sv =====
`timescale 1ns / 1ps

// Bounded min-first priority queue built as a sorted row of cells, one entry per
// cell, with the smallest priority number always in the head cell. Every cycle
// each cell either keeps its entry, takes the incoming pair, or takes its
// neighbor's entry, so an enqueue or dequeue never holds the queue busy and
// busy stays low: a transaction can be started in every cycle. The result of a
// transaction appears on the cycle after start, marked by done for exactly one
// cycle; the receiver cannot stall, so it must capture each result when done is
// high. Equal priorities are served in insertion order. A dequeue on an empty
// queue returns status empty and value -1; an enqueue on a full queue is
// dropped with status full.
module min_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic signed [mpq_pkg::VALUE_W-1:0]  entry_value,
    input  logic [mpq_pkg::PRI_W-1:0]           entry_priority,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [mpq_pkg::VALUE_W-1:0]  out_value,
    output logic [mpq_pkg::COUNT_OUT_W-1:0]     entry_count,
    output logic                                is_empty,
    output logic                                is_full
);

    localparam logic [mpq_pkg::CNT_W-1:0] CAP_COUNT = mpq_pkg::CNT_W'(mpq_pkg::CAPACITY);
    localparam logic [mpq_pkg::CNT_W-1:0] CNT_ONE = mpq_pkg::CNT_W'(1);

    logic                                 accept;
    logic                                 full;
    logic                                 empty;
    logic [mpq_pkg::CNT_W-1:0]            count_reg;
    logic [mpq_pkg::CNT_W-1:0]            count_next;
    logic                                 done_reg;
    mpq_pkg::status_t                     status_reg;
    mpq_pkg::status_t                     status_next;
    logic signed [mpq_pkg::VALUE_W-1:0]   value_reg;
    logic signed [mpq_pkg::VALUE_W-1:0]   value_next;
    logic [mpq_pkg::COUNT_OUT_W-1:0]      entry_count_reg;
    logic                                 is_empty_reg;
    logic                                 is_full_reg;
    mpq_pkg::cell_ctrl_t                  ctrl;
    mpq_pkg::cell_t                       cells [mpq_pkg::CAPACITY+1];
    logic                                 gos [mpq_pkg::CAPACITY+1];
    logic [mpq_pkg::CAPACITY-1:0]         valid_vec;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CAP_COUNT);
    assign empty  = (count_reg == '0);

    assign ctrl.enq   = accept && (opcode == mpq_pkg::OP_ENQUEUE) && !full;
    assign ctrl.deq   = accept && (opcode == mpq_pkg::OP_DEQUEUE) && !empty;
    assign ctrl.pri   = entry_priority;
    assign ctrl.value = entry_value;

    // Index 0 is the free slot left of the head; index i+1 is cell i. The slot
    // right of the last cell is a separate all-zero empty entry.
    assign cells[0] = '0;
    assign gos[0]   = 1'b0;

    for (genvar i = 0; i < mpq_pkg::CAPACITY; i++)
    begin : g_cell
        mpq_pkg::cell_t right_cell;

        if (i == mpq_pkg::CAPACITY - 1)
        begin : g_last
            assign right_cell = '0;
        end
        else
        begin : g_inner
            assign right_cell = cells[i+2];
        end

        mpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_cell  (cells[i]),
            .left_go    (gos[i]),
            .right_cell (right_cell),
            .slot       (cells[i+1]),
            .go         (gos[i+1])
        );

        assign valid_vec[i] = cells[i+1].valid;
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = mpq_pkg::ST_OK;
        value_next  = '0;
        if (opcode == mpq_pkg::OP_ENQUEUE)
        begin
            if (full)
            begin
                status_next = mpq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_ONE;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = mpq_pkg::ST_EMPTY;
                value_next  = '1;
            end
            else
            begin
                value_next = cells[1].value;
                count_next = count_reg - CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            value_reg       <= value_next;
            entry_count_reg <= mpq_pkg::COUNT_OUT_W'(count_next);
            is_empty_reg    <= (count_next == '0);
            is_full_reg     <= (count_next == CAP_COUNT);
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_value   = value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;

`ifndef ASSERT_OFF
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept))
        else $error("Result strobe does not match the accepted transaction.");

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == count_reg)
        else $error("Occupied cells disagree with the entry count.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_empty && is_full))
        else $error("Result reports empty and full together.");

    a_full_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == mpq_pkg::OP_ENQUEUE && full) |=> $stable(count_reg))
        else $error("Rejected enqueue changed the entry count.");
`endif

endmodule
